[hdl/mbrs_pkg.sv]
// ----------------------------------------------------------------------------
// mbrs_pkg
// shared types, register indexes and divider step for the roi sampler
// ----------------------------------------------------------------------------
package mbrs_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_SCALE  = 3'd4;

    localparam logic [5:0]  RST_MAP_HEIGHT = 6'd16;
    localparam logic [5:0]  RST_MAP_WIDTH  = 6'd16;
    localparam logic [5:0]  RST_OUT_HEIGHT = 6'd9;
    localparam logic [5:0]  RST_OUT_WIDTH  = 6'd9;
    localparam logic [16:0] RST_ROI_SCALE  = 17'd4096;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // dividend row*size*256 and divisor out_size-1
    localparam int NUM_W = 19;
    localparam int DEN_W = 6;
    localparam int BOX_W = 29;

    typedef struct packed {
        logic               op;
        logic               image;
        logic [2:0]         channel;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] sample;
        logic [BOX_W-1:0]   y0s;
        logic [BOX_W-1:0]   y1s;
        logic [BOX_W-1:0]   x0s;
        logic [BOX_W-1:0]   x1s;
    } req_t;

    // one restoring step: {remainder, dividend/quotient}
    function automatic logic [DEN_W+NUM_W-1:0] div_step(
        input logic [DEN_W+NUM_W-1:0] x,
        input logic [DEN_W-1:0]       den
    );
        logic [DEN_W:0]   tmp;
        logic [NUM_W-1:0] nq;
        tmp = {x[DEN_W+NUM_W-1:NUM_W], x[NUM_W-1]};
        nq  = {x[NUM_W-2:0], 1'b0};
        if (tmp >= {1'b0, den})
        begin
            tmp   = tmp - {1'b0, den};
            nq[0] = 1'b1;
        end
        return {tmp[DEN_W-1:0], nq};
    endfunction

endpackage

[hdl/mbrs_div.sv]
// ----------------------------------------------------------------------------
// mbrs_div
// pipelined restoring divider for row and column positions, one bit a stage
// ----------------------------------------------------------------------------
module mbrs_div
    import mbrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  req_t             in_req,
    input  logic [NUM_W-1:0] in_num_h,
    input  logic [NUM_W-1:0] in_num_w,
    input  logic [DEN_W-1:0] den_h,
    input  logic [DEN_W-1:0] den_w,
    output logic             out_valid,
    output req_t             out_req,
    output logic [NUM_W-1:0] out_quo_h,
    output logic [NUM_W-1:0] out_quo_w
);

    logic [NUM_W-1:0]       vld_reg;
    req_t                   req_reg [NUM_W];
    logic [DEN_W+NUM_W-1:0] h_reg   [NUM_W];
    logic [DEN_W+NUM_W-1:0] w_reg   [NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req_reg[0] <= in_req;
            h_reg[0]   <= div_step({{DEN_W{1'b0}}, in_num_h}, den_h);
            w_reg[0]   <= div_step({{DEN_W{1'b0}}, in_num_w}, den_w);
            for (int k = 1; k < NUM_W; k++)
            begin
                req_reg[k] <= req_reg[k-1];
                h_reg[k]   <= div_step(h_reg[k-1], den_h);
                w_reg[k]   <= div_step(w_reg[k-1], den_w);
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_req   = req_reg[NUM_W-1];
    assign out_quo_h = h_reg[NUM_W-1][NUM_W-1:0];
    assign out_quo_w = w_reg[NUM_W-1][NUM_W-1:0];

endmodule

[hdl/masked_bilinear_roi_sampler.sv]
// ----------------------------------------------------------------------------
// masked_bilinear_roi_sampler
// bilinear feature map sampler with a scaled discard box, banked map store
// ----------------------------------------------------------------------------
// usage
//   s_tuser selects the transfer kind: 0 writes one map sample, 1 requests
//   one output sample. a request yields one m_tdata transfer, a write none.
//   cfg_* writes the five size and scale registers while the block is idle.
//   the map is held in four banks split by row and column parity, so all
//   four neighbours are read in the same cycle; writes and reads pass through
//   the same pipeline, so a request always sees the writes accepted before it.
//   one transfer is accepted every cycle while s_tready is high. a result
//   shows on m_tvalid after passing the 19 stage position divider, the bank
//   read, the multiply and sum stages and the output buffer.
//   a two entry output buffer keeps s_tready registered; when the receiver
//   stalls and the spare slot fills, the whole pipeline holds and s_tready drops.
//   reset clears the pipeline and loads the register defaults; map contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module masked_bilinear_roi_sampler
    import mbrs_pkg::*;
#(
    parameter int MAX_HEIGHT = 32,
    parameter int MAX_WIDTH  = 32,
    parameter int CHANNELS   = 8,
    parameter int IMAGES     = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // image, channel, row, col, sample, roi_x0, roi_y0, roi_x1, roi_y1
    input  logic [79:0]          s_tdata,
    // op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value
    output logic [15:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]          cfg_data
);

    localparam int BANK_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_W     = (MAX_WIDTH + 1) / 2;
    localparam int BANK_DEPTH = IMAGES * CHANNELS * BANK_H * BANK_W;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    function automatic logic [BANK_AW-1:0] bank_addr(
        input logic       img,
        input logic [2:0] ch,
        input logic [6:0] rb,
        input logic [6:0] cb
    );
        int a;
        a = ((int'(img) * CHANNELS + int'(ch)) * BANK_H + int'(rb)) * BANK_W + int'(cb);
        return BANK_AW'(a);
    endfunction

    // configuration
    logic [5:0]  map_height_reg, map_width_reg, out_height_reg, out_width_reg;
    logic [16:0] roi_scale_reg;
    logic [5:0]  mh, mw, oh_m1, ow_m1;
    logic [16:0] sc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_height_reg <= RST_MAP_HEIGHT;
            map_width_reg  <= RST_MAP_WIDTH;
            out_height_reg <= RST_OUT_HEIGHT;
            out_width_reg  <= RST_OUT_WIDTH;
            roi_scale_reg  <= RST_ROI_SCALE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data[5:0];
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[5:0];
                CFG_OUT_HEIGHT: out_height_reg <= cfg_data[5:0];
                CFG_OUT_WIDTH:  out_width_reg  <= cfg_data[5:0];
                CFG_ROI_SCALE:  roi_scale_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign mh = (map_height_reg == 6'd0) ? 6'd1 :
                (int'(map_height_reg) > MAX_HEIGHT) ? 6'(MAX_HEIGHT) : map_height_reg;
    assign mw = (map_width_reg == 6'd0) ? 6'd1 :
                (int'(map_width_reg) > MAX_WIDTH) ? 6'(MAX_WIDTH) : map_width_reg;
    assign oh_m1 = (out_height_reg < 6'd2) ? 6'd1 : out_height_reg - 6'd1;
    assign ow_m1 = (out_width_reg < 6'd2) ? 6'd1 : out_width_reg - 6'd1;
    assign sc    = roi_scale_reg[16] ? 17'h10000 : roi_scale_reg;

    // output buffer control, pipeline advances while the spare slot is free
    logic        main_valid_reg, extra_valid_reg;
    logic [15:0] main_data_reg, extra_data_reg;
    logic        en, push, pop;
    logic [15:0] push_data;

    assign en       = !extra_valid_reg;
    assign s_tready = en;

    // input register
    logic p0_valid_reg;
    req_t p0_req_reg;
    req_t in_req;

    always_comb
    begin
        in_req.op      = s_tuser;
        in_req.image   = s_tdata[0];
        in_req.channel = s_tdata[3:1];
        in_req.row     = s_tdata[8:4];
        in_req.col     = s_tdata[13:9];
        in_req.sample  = s_tdata[29:14];
        in_req.x0s     = BOX_W'(s_tdata[41:30]) * BOX_W'(sc);
        in_req.y0s     = BOX_W'(s_tdata[53:42]) * BOX_W'(sc);
        in_req.x1s     = BOX_W'(s_tdata[65:54]) * BOX_W'(sc);
        in_req.y1s     = BOX_W'(s_tdata[77:66]) * BOX_W'(sc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_req_reg <= in_req;
        end
    end

    // position divider
    logic [10:0]      rm_h, rm_w;
    logic             d_valid;
    req_t             d_req;
    logic [NUM_W-1:0] quo_h, quo_w;

    assign rm_h = 11'(p0_req_reg.row) * 11'(mh);
    assign rm_w = 11'(p0_req_reg.col) * 11'(mw);

    mbrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p0_valid_reg),
        .in_req    (p0_req_reg),
        .in_num_h  ({rm_h, 8'd0}),
        .in_num_w  ({rm_w, 8'd0}),
        .den_h     (oh_m1),
        .den_w     (ow_m1),
        .out_valid (d_valid),
        .out_req   (d_req),
        .out_quo_h (quo_h),
        .out_quo_w (quo_w)
    );

    // neighbour selection, box test and bank addressing
    logic               a_valid_reg, a_op_reg, a_wok_reg, a_past_reg;
    logic               a_hpar_reg, a_wpar_reg;
    logic signed [15:0] a_sample_reg;
    logic [1:0]         a_wbank_reg;
    logic [BANK_AW-1:0] a_waddr_reg;
    logic [BANK_AW-1:0] a_raddr_reg [4];
    logic [3:0]         a_keep_reg;
    logic [7:0]         a_hf_reg, a_wf_reg;

    logic               past_next, icok, wok_next;
    logic [6:0]         r_pos [2];
    logic [6:0]         c_pos [2];
    logic [1:0]         in_r, in_c, ok_r, ok_c;
    logic [3:0]         keep_next;
    logic [BANK_AW-1:0] raddr_next [4];
    logic [6:0]         rsel, csel;

    always_comb
    begin
        past_next = (quo_h > NUM_W'({mh, 8'd0})) || (quo_w > NUM_W'({mw, 8'd0}));
        icok      = (int'(d_req.image) < IMAGES) && (int'(d_req.channel) < CHANNELS);
        wok_next  = (d_req.op == OP_WRITE) && icok && (int'(d_req.row) < MAX_HEIGHT) &&
                    (int'(d_req.col) < MAX_WIDTH);
        r_pos[0]  = {1'b0, quo_h[13:8]};
        r_pos[1]  = {1'b0, quo_h[13:8]} + 7'd1;
        c_pos[0]  = {1'b0, quo_w[13:8]};
        c_pos[1]  = {1'b0, quo_w[13:8]} + 7'd1;
        for (int i = 0; i < 2; i++)
        begin
            in_r[i] = (BOX_W'({r_pos[i], 16'd0}) >= d_req.y0s) &&
                      (BOX_W'({r_pos[i], 16'd0}) <= d_req.y1s);
            in_c[i] = (BOX_W'({c_pos[i], 16'd0}) >= d_req.x0s) &&
                      (BOX_W'({c_pos[i], 16'd0}) <= d_req.x1s);
            ok_r[i] = r_pos[i] < {1'b0, mh};
            ok_c[i] = c_pos[i] < {1'b0, mw};
        end
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                keep_next[i*2+j] = !(in_r[i] && in_c[j]) && ok_r[i] && ok_c[j] && icok;
            end
        end
        // bank b holds rows of parity b[1] and columns of parity b[0]
        for (int b = 0; b < 4; b++)
        begin
            rsel = (quo_h[8] == b[1]) ? r_pos[0] : r_pos[1];
            csel = (quo_w[8] == b[0]) ? c_pos[0] : c_pos[1];
            if ((rsel < {1'b0, mh}) && (csel < {1'b0, mw}) && icok)
            begin
                raddr_next[b] = bank_addr(d_req.image, d_req.channel, rsel >> 1, csel >> 1);
            end
            else
            begin
                raddr_next[b] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg     <= d_req.op;
            a_wok_reg    <= wok_next;
            a_past_reg   <= past_next;
            a_hpar_reg   <= quo_h[8];
            a_wpar_reg   <= quo_w[8];
            a_sample_reg <= d_req.sample;
            a_wbank_reg  <= {d_req.row[0], d_req.col[0]};
            a_waddr_reg  <= bank_addr(d_req.image, d_req.channel,
                                      7'(d_req.row >> 1), 7'(d_req.col >> 1));
            a_keep_reg   <= keep_next;
            a_hf_reg     <= quo_h[7:0];
            a_wf_reg     <= quo_w[7:0];
            for (int b = 0; b < 4; b++)
            begin
                a_raddr_reg[b] <= raddr_next[b];
            end
        end
    end

    // map banks
    logic               rd_valid_reg, rd_op_reg, rd_past_reg, rd_hpar_reg, rd_wpar_reg;
    logic [3:0]         rd_keep_reg;
    logic [7:0]         rd_hf_reg, rd_wf_reg;
    logic signed [15:0] rdata_reg [4];

    genvar gb;
    generate
        for (gb = 0; gb < 4; gb++)
        begin : g_bank
            logic [15:0] mem [BANK_DEPTH];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (a_valid_reg && a_wok_reg && (a_wbank_reg == 2'(gb)))
                    begin
                        mem[a_waddr_reg] <= a_sample_reg;
                    end
                    rdata_reg[gb] <= mem[a_raddr_reg[gb]];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rd_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_op_reg   <= a_op_reg;
            rd_past_reg <= a_past_reg;
            rd_hpar_reg <= a_hpar_reg;
            rd_wpar_reg <= a_wpar_reg;
            rd_keep_reg <= a_keep_reg;
            rd_hf_reg   <= a_hf_reg;
            rd_wf_reg   <= a_wf_reg;
        end
    end

    // row weights
    logic               wy_valid_reg, wy_op_reg, wy_past_reg;
    logic [7:0]         wy_wf_reg;
    logic signed [25:0] wy_prod_reg [4];
    logic signed [25:0] wy_prod_next [4];
    logic signed [25:0] nv, wgt;
    logic [1:0]         bsel;

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            bsel = {rd_hpar_reg ^ n[1], rd_wpar_reg ^ n[0]};
            nv   = rd_keep_reg[n] ? 26'(rdata_reg[bsel]) : 26'sd0;
            wgt  = n[1] ? $signed({18'd0, rd_hf_reg}) : $signed(26'd256 - {18'd0, rd_hf_reg});
            wy_prod_next[n] = nv * wgt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wy_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            wy_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wy_op_reg   <= rd_op_reg;
            wy_past_reg <= rd_past_reg;
            wy_wf_reg   <= rd_wf_reg;
            for (int n = 0; n < 4; n++)
            begin
                wy_prod_reg[n] <= wy_prod_next[n];
            end
        end
    end

    // column weights
    logic               wx_valid_reg, wx_op_reg, wx_past_reg;
    logic signed [35:0] wx_prod_reg [4];
    logic signed [35:0] wx_prod_next [4];
    logic signed [35:0] pv, cw;

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            pv = 36'(wy_prod_reg[n]);
            cw = n[0] ? $signed({28'd0, wy_wf_reg}) : $signed(36'd256 - {28'd0, wy_wf_reg});
            wx_prod_next[n] = pv * cw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            wx_valid_reg <= wy_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_op_reg   <= wy_op_reg;
            wx_past_reg <= wy_past_reg;
            for (int n = 0; n < 4; n++)
            begin
                wx_prod_reg[n] <= wx_prod_next[n];
            end
        end
    end

    // sum with rounding offset
    logic               sm_valid_reg, sm_op_reg;
    logic signed [35:0] sm_sum_reg;
    logic signed [35:0] sm_sum_next;

    assign sm_sum_next = wx_past_reg ? 36'sd0 :
                         wx_prod_reg[0] + wx_prod_reg[1] + wx_prod_reg[2] + wx_prod_reg[3] +
                         36'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sm_valid_reg <= wx_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_op_reg  <= wx_op_reg;
            sm_sum_reg <= sm_sum_next;
        end
    end

    // floor shift and saturation
    logic signed [19:0] q;

    assign q = sm_sum_reg[35:16];
    assign push_data = (q > 20'sd32767)  ? 16'h7fff :
                       (q < -20'sd32768) ? 16'h8000 : q[15:0];
    assign push = en && sm_valid_reg && (sm_op_reg == OP_REQUEST);
    assign pop  = main_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            extra_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg  <= extra_valid_reg || push;
            extra_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            extra_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_data_reg <= extra_valid_reg ? extra_data_reg : push_data;
        end
        else if (push)
        begin
            extra_data_reg <= push_data;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

    // spare slot only holds data behind a full main slot
    assert property (@(posedge clk) disable iff (!rst_n)
        extra_valid_reg |-> main_valid_reg)
        else $error("spare output slot used while main slot empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(extra_valid_reg) |-> $past(push) && $past(main_valid_reg && !m_tready))
        else $error("spare output slot filled without a stalled result");

    assert property (@(posedge clk) disable iff (!rst_n)
        extra_valid_reg |-> !push)
        else $error("result pushed while pipeline held");

endmodule

[tb/tb_masked_bilinear_roi_sampler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_bilinear_roi_sampler
// self-checking bench for the masked bilinear roi sampler
// ----------------------------------------------------------------------------
// loads map samples and issues sample requests over the stream input while
// the register settings are swept between phases. a scoreboard keeps its own
// copy of the map and registers, predicts each request's interpolated value
// and compares it with every output transfer in order. both sides idle at
// random, and one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb_masked_bilinear_roi_sampler;
    import mbrs_pkg::*;

    localparam int  STORE_DEPTH = 2 * 8 * 32 * 32;
    localparam int  TAIL_CYCLES = 40;
    localparam int  CYCLE_LIMIT = 1000000;

    typedef struct {
        logic        op;
        logic        image;
        logic [2:0]  channel;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [15:0] sample;
        logic [11:0] x0;
        logic [11:0] y0;
        logic [11:0] x1;
        logic [11:0] y1;
    } item_t;

    class roi_scoreboard;
        logic [15:0] store [STORE_DEPTH];
        bit          written [STORE_DEPTH];
        logic [5:0]  map_h, map_w, out_h, out_w;
        logic [16:0] scale;
        logic [15:0] expected_q [$];
        int          errors, checked, requests;

        function new();
            map_h = RST_MAP_HEIGHT;
            map_w = RST_MAP_WIDTH;
            out_h = RST_OUT_HEIGHT;
            out_w = RST_OUT_WIDTH;
            scale = RST_ROI_SCALE;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] data);
            case (idx)
                CFG_MAP_HEIGHT: map_h = data[5:0];
                CFG_MAP_WIDTH:  map_w = data[5:0];
                CFG_OUT_HEIGHT: out_h = data[5:0];
                CFG_OUT_WIDTH:  out_w = data[5:0];
                CFG_ROI_SCALE:  scale = data;
                default: ;
            endcase
        endfunction

        function bit in_box(longint unsigned p, longint unsigned lo,
                            longint unsigned hi, longint unsigned sc);
            return ((p << 16) >= lo * sc) && ((p << 16) <= hi * sc);
        endfunction

        // interpolated value; miss names the first unwritten entry needed
        function void interpolate(item_t it, output logic [15:0] v, output int miss);
            longint unsigned mh, mw, oh, ow, sc, hq, wq;
            longint          wy [2];
            longint          wx [2];
            longint          sum, t, q;
            int              hs, ws, r, c, a;
            miss = -1;
            v    = '0;
            sum  = 0;
            mh = (map_h < 1) ? 1 : ((map_h > 32) ? 32 : map_h);
            mw = (map_w < 1) ? 1 : ((map_w > 32) ? 32 : map_w);
            oh = (out_h < 2) ? 2 : out_h;
            ow = (out_w < 2) ? 2 : out_w;
            sc = (scale > 65536) ? 65536 : scale;
            hq = (longint'(it.row) * mh * 256) / (oh - 1);
            wq = (longint'(it.col) * mw * 256) / (ow - 1);
            if (hq > mh * 256 || wq > mw * 256)
                return;
            hs = int'(hq >> 8);
            ws = int'(wq >> 8);
            wy[0] = 256 - (hq & 255);
            wy[1] = hq & 255;
            wx[0] = 256 - (wq & 255);
            wx[1] = wq & 255;
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    r = hs + i;
                    c = ws + j;
                    if (in_box(r, it.y0, it.y1, sc) && in_box(c, it.x0, it.x1, sc))
                        continue;
                    if (r >= mh || c >= mw)
                        continue;
                    a = ((int'(it.image) * 8 + int'(it.channel)) * 32 + r) * 32 + c;
                    if (!written[a])
                    begin
                        miss = a;
                        return;
                    end
                    sum += longint'($signed(store[a])) * wy[i] * wx[j];
                end
            end
            t = sum + 32768;
            q = t >>> 16;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            v = q[15:0];
        endfunction

        function void note_input(item_t it);
            logic [15:0] v;
            int          a, miss;
            if (it.op == OP_WRITE)
            begin
                a = ((int'(it.image) * 8 + int'(it.channel)) * 32 + int'(it.row)) * 32
                    + int'(it.col);
                store[a]   = it.sample;
                written[a] = 1'b1;
            end
            else
            begin
                interpolate(it, v, miss);
                expected_q.push_back(v);
                requests++;
            end
        endfunction

        function void check_value(logic [15:0] actual);
            logic [15:0] exp_v;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected output transfer, value %h", $time, actual);
                errors++;
                return;
            end
            exp_v = expected_q.pop_front();
            checked++;
            if (actual !== exp_v)
            begin
                $display("%0t: value mismatch, expected %h actual %h", $time, exp_v, actual);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [79:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [16:0]          cfg_data;

    roi_scoreboard sb;
    int            cycles;
    int            items_sent;
    bit            tx_idle_on;
    bit            rx_idle_on;
    bit            hold_request;

    masked_bilinear_roi_sampler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side: random stalls plus one long hold-off on request
    initial
    begin
        int wait_cnt;
        wait_cnt = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready = 1'b0;
                repeat (400) @(negedge clk);
            end
            if (wait_cnt > 0)
            begin
                m_tready = 1'b0;
                wait_cnt--;
            end
            else
            begin
                m_tready = 1'b1;
                if (rx_idle_on)
                    wait_cnt = pick_gap();
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_value(m_tdata);

    task automatic send_item(item_t it);
        int gap;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = it.op;
        s_tdata  = {2'b00, it.y1, it.x1, it.y0, it.x0, it.sample,
                    it.col, it.row, it.channel, it.image};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(it);
        items_sent++;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // loads any map entry the request would read before it goes out
    task automatic issue_request(item_t it);
        item_t       wr;
        logic [15:0] v;
        int          miss;
        sb.interpolate(it, v, miss);
        while (miss >= 0)
        begin
            wr.op      = OP_WRITE;
            wr.image   = 1'(miss / 8192);
            wr.channel = 3'((miss / 1024) % 8);
            wr.row     = 5'((miss / 32) % 32);
            wr.col     = 5'(miss % 32);
            wr.sample  = 16'($urandom);
            wr.x0 = 12'($urandom); wr.y0 = 12'($urandom);
            wr.x1 = 12'($urandom); wr.y1 = 12'($urandom);
            send_item(wr);
            sb.interpolate(it, v, miss);
        end
        send_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        end_burst();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic item_t make_request(int img, int ch, int r, int c,
                                           int x0, int y0, int x1, int y1);
        item_t it;
        it.op = OP_REQUEST; it.image = 1'(img); it.channel = 3'(ch);
        it.row = 5'(r); it.col = 5'(c); it.sample = 16'($urandom);
        it.x0 = 12'(x0); it.y0 = 12'(y0); it.x1 = 12'(x1); it.y1 = 12'(y1);
        return it;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned sc, lim, oh, ow;
        it.op      = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_REQUEST;
        it.image   = 1'($urandom);
        it.channel = 3'($urandom);
        it.sample  = 16'($urandom);
        sc  = (sb.scale == 0) ? 1 : ((sb.scale > 65536) ? 65536 : sb.scale);
        lim = (33 * 65536) / sc;
        if (lim > 4095)
            lim = 4095;
        if ($urandom_range(0, 7) == 0)
        begin
            it.x0 = 12'($urandom); it.y0 = 12'($urandom);
            it.x1 = 12'($urandom); it.y1 = 12'($urandom);
        end
        else
        begin
            it.x0 = 12'($urandom_range(0, lim)); it.x1 = 12'($urandom_range(0, lim));
            it.y0 = 12'($urandom_range(0, lim)); it.y1 = 12'($urandom_range(0, lim));
        end
        oh = (sb.out_h < 2) ? 2 : sb.out_h;
        ow = (sb.out_w < 2) ? 2 : sb.out_w;
        if (it.op == OP_REQUEST && $urandom_range(0, 9) != 0)
        begin
            it.row = 5'($urandom_range(0, (oh - 1 > 31) ? 31 : oh - 1));
            it.col = 5'($urandom_range(0, (ow - 1 > 31) ? 31 : ow - 1));
        end
        else
        begin
            it.row = 5'($urandom);
            it.col = 5'($urandom);
        end
        return it;
    endfunction

    initial
    begin
        item_t       it;
        logic [16:0] settings [8][5];
        int          n, phase_end;
        sb = new();
        cycles = 0;
        items_sent = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_request = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        settings = '{'{1, 1, 2, 2, 1},
                     '{32, 32, 32, 32, 65536},
                     '{0, 63, 0, 1, 131071},
                     '{7, 20, 5, 13, 30000},
                     '{32, 1, 2, 32, 512},
                     '{63, 0, 63, 40, 100000},
                     '{12, 9, 17, 3, 65535},
                     '{16, 16, 9, 9, 4096}};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, full discard, inverted box, edges, past the map
        it = make_request(1, 7, 0, 0, 0, 0, 0, 0);
        it.op = OP_WRITE; it.sample = 16'h7fff;
        send_item(it);
        it.col = 1; it.sample = 16'h8000;
        send_item(it);
        it.row = 1; it.col = 0; it.sample = 16'h7fff;
        send_item(it);
        it.col = 1; it.sample = 16'h8000;
        send_item(it);
        issue_request(make_request(1, 7, 0, 0, 4095, 4095, 0, 0));
        issue_request(make_request(1, 7, 0, 1, 4095, 4095, 0, 0));
        issue_request(make_request(1, 7, 0, 0, 0, 0, 4095, 4095));
        issue_request(make_request(1, 7, 0, 0, 0, 0, 0, 0));
        issue_request(make_request(0, 0, 8, 8, 4095, 4095, 0, 0));
        issue_request(make_request(0, 0, 8, 3, 4095, 4095, 0, 0));
        issue_request(make_request(0, 0, 9, 0, 0, 0, 0, 0));
        issue_request(make_request(0, 0, 31, 31, 0, 0, 0, 0));
        issue_request(make_request(1, 3, 5, 7, 32, 64, 96, 128));
        issue_request(make_request(0, 5, 4, 4, 96, 0, 16, 4095));
        wait_idle();
        write_reg(3'd5, 17'h1ffff);
        write_reg(3'd7, 17'd3);

        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            for (int k = 0; k < 5; k++)
                write_reg(CFG_IDX_W'(k), settings[p][k]);
            tx_idle_on = (p != 3);
            rx_idle_on = (p != 5);
            n = 0;
            phase_end = items_sent + 215;
            while (items_sent < phase_end)
            begin
                if (p == 2 && n == 20)
                begin
                    tx_idle_on = 1'b0;
                    hold_request = 1'b1;
                end
                if (p == 2 && n == 120)
                    tx_idle_on = 1'b1;
                it = random_item();
                if (it.op == OP_WRITE)
                    send_item(it);
                else
                    issue_request(it);
                n++;
            end
        end

        wait_idle();
        $display("%0d transfers in, %0d requests checked over 8 register settings",
                 items_sent, sb.checked);
        $display("covered discard boxes, inverted boxes, map edges and pipeline stall");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hdl/mbrs_pkg.sv
hdl/mbrs_div.sv
hdl/masked_bilinear_roi_sampler.sv
tb/tb_masked_bilinear_roi_sampler.sv
